>>> rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants for the PNG chunk deframer.
// ----------------------------------------------------------------------------
package pcd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pcd_in_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [2:0]  byte_role;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic [31:0] chunk_crc;
    logic        chunk_end;
    logic        chunk_is_idat;
    logic        chunk_is_iend;
    logic [1:0]  status;
    logic        stream_end;
  } pcd_out_t;

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_IDLE = 6'b100000
  } pcd_phase_t;

  localparam logic [2:0] ROLE_SIG  = 3'd0;
  localparam logic [2:0] ROLE_LEN  = 3'd1;
  localparam logic [2:0] ROLE_TYPE = 3'd2;
  localparam logic [2:0] ROLE_DATA = 3'd3;
  localparam logic [2:0] ROLE_CRC  = 3'd4;
  localparam logic [2:0] ROLE_IGN  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIG   = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_NO_CHUNK  = 2'd3;

  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [3:0]  MIN_CHUNK = 4'd12;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/pcd_parser.sv
// ----------------------------------------------------------------------------
// pcd_parser
// Per-byte parse state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module pcd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  pcd_pkg::pcd_in_t  in_item,
  output pcd_pkg::pcd_out_t result
);
  import pcd_pkg::*;

  pcd_phase_t  phase_r, phase_nxt;
  logic [2:0]  sig_idx_r, sig_idx_nxt;
  logic [1:0]  fcnt_r, fcnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [3:0]  prog_r, prog_nxt;
  logic        seen_r, seen_nxt;
  logic        sig_err_r, sig_err_nxt;

  logic [7:0]  b;
  logic        last;
  logic [2:0]  role;
  logic        end_w, idat_w, iend_w;
  logic [1:0]  status_w;
  logic        in_chunk;

  assign b    = in_item.data_byte;
  assign last = in_item.last_byte;

  always_comb begin
    phase_nxt   = phase_r;
    sig_idx_nxt = sig_idx_r;
    fcnt_nxt    = fcnt_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    crc_nxt     = crc_r;
    remain_nxt  = remain_r;
    prog_nxt    = prog_r;
    seen_nxt    = seen_r;
    sig_err_nxt = sig_err_r;
    role        = ROLE_IGN;
    end_w       = 1'b0;
    idat_w      = 1'b0;
    iend_w      = 1'b0;

    if ((phase_r == PH_LEN || phase_r == PH_TYPE || phase_r == PH_DATA ||
         phase_r == PH_CRC) && prog_r < MIN_CHUNK) begin
      prog_nxt = prog_r + 4'd1;
    end

    case (phase_r)
      PH_SIG: begin
        role = ROLE_SIG;
        if (b != sig_byte(sig_idx_r)) begin
          sig_err_nxt = 1'b1;
          phase_nxt   = PH_IDLE;
        end else if (sig_idx_r == 3'd7) begin
          phase_nxt = PH_LEN;
          fcnt_nxt  = 2'd0;
          prog_nxt  = 4'd0;
        end else begin
          sig_idx_nxt = sig_idx_r + 3'd1;
        end
      end
      PH_LEN: begin
        role = ROLE_LEN;
        if (fcnt_r == 2'd0) begin
          // first length byte opens a new chunk
          len_nxt  = {24'd0, b};
          type_nxt = 32'd0;
          crc_nxt  = 32'd0;
        end else begin
          len_nxt = {len_r[23:0], b};
        end
        fcnt_nxt = fcnt_r + 2'd1;
        if (fcnt_r == 2'd3) begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        role     = ROLE_TYPE;
        type_nxt = {type_r[23:0], b};
        fcnt_nxt = fcnt_r + 2'd1;
        if (fcnt_r == 2'd3) begin
          remain_nxt = len_r;
          phase_nxt  = (len_r == 32'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        role = ROLE_DATA;
        if (remain_r != 32'd0) begin
          remain_nxt = remain_r - 32'd1;
        end
        if (remain_r <= 32'd1) begin
          fcnt_nxt  = 2'd0;
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        role     = ROLE_CRC;
        crc_nxt  = {crc_r[23:0], b};
        fcnt_nxt = fcnt_r + 2'd1;
        if (fcnt_r == 2'd3) begin
          end_w     = 1'b1;
          seen_nxt  = 1'b1;
          prog_nxt  = 4'd0;
          idat_w    = (type_r == TYPE_IDAT);
          iend_w    = (type_r == TYPE_IEND);
          phase_nxt = (type_r == TYPE_IEND) ? PH_IDLE : PH_LEN;
        end
      end
      default: begin
        role = ROLE_IGN;
      end
    endcase

    in_chunk = (phase_nxt == PH_LEN || phase_nxt == PH_TYPE ||
                phase_nxt == PH_DATA || phase_nxt == PH_CRC);

    status_w = sig_err_nxt ? ST_BAD_SIG : ST_OK;
    if (last) begin
      if (sig_err_nxt || phase_nxt == PH_SIG) begin
        status_w = ST_BAD_SIG;
      end else if (in_chunk && prog_nxt >= MIN_CHUNK) begin
        status_w = ST_TRUNCATED;
      end else if (!seen_nxt) begin
        status_w = ST_NO_CHUNK;
      end else begin
        status_w = ST_OK;
      end
    end

    result.data_out      = b;
    result.byte_role     = role;
    result.chunk_length  = len_nxt;
    result.chunk_type    = type_nxt;
    result.chunk_crc     = crc_nxt;
    result.chunk_end     = end_w;
    result.chunk_is_idat = idat_w;
    result.chunk_is_iend = iend_w;
    result.status        = status_w;
    result.stream_end    = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      // final byte returns the parser to its power-on state
      phase_r   <= PH_SIG;
      sig_idx_r <= 3'd0;
      fcnt_r    <= 2'd0;
      len_r     <= 32'd0;
      type_r    <= 32'd0;
      crc_r     <= 32'd0;
      remain_r  <= 32'd0;
      prog_r    <= 4'd0;
      seen_r    <= 1'b0;
      sig_err_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      sig_idx_r <= sig_idx_nxt;
      fcnt_r    <= fcnt_nxt;
      len_r     <= len_nxt;
      type_r    <= type_nxt;
      crc_r     <= crc_nxt;
      remain_r  <= remain_nxt;
      prog_r    <= prog_nxt;
      seen_r    <= seen_nxt;
      sig_err_r <= sig_err_nxt;
    end
  end

endmodule

>>> rtl/pcd_out_buf.sv
// ----------------------------------------------------------------------------
// pcd_out_buf
// Result register with a skid entry, so input acceptance does not wait on
// the downstream ready.
// ----------------------------------------------------------------------------
module pcd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pcd_pkg::pcd_out_t  push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output pcd_pkg::pcd_out_t  out_data
);
  import pcd_pkg::*;

  pcd_out_t main_r;
  pcd_out_t skid_r;
  logic     main_valid_r;
  logic     skid_valid_r;
  logic     main_free;
  logic     load_main;
  logic     load_skid;

  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign main_free = !main_valid_r || out_ready;
  assign load_main = main_free && (skid_valid_r || push);
  assign load_skid = !main_free && push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (main_free) begin
        main_valid_r <= skid_valid_r || push;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end
    if (load_skid) begin
      skid_r <= push_data;
    end
  end

endmodule

>>> rtl/png_chunk_deframer_unit.sv
// ----------------------------------------------------------------------------
// png_chunk_deframer_unit
// PNG byte-stream deframer: signature check, chunk split and byte tagging.
// ----------------------------------------------------------------------------
// Takes one byte of a PNG file per cycle while in_ready is high and returns
// one tagged result per byte, with the chunk length, type and stored CRC as
// assembled so far, a chunk end mark with flags for IDAT and IEND, and on the
// byte flagged last the verdict for the whole file. The parse state loads at
// the edge that accepts the byte; if the output is free, the output register
// loads at that edge too, so the result is offered in the next cycle. While
// the output is stalled the result waits in a skid entry behind that register,
// which keeps the input open for one more byte. The CRC is carried, not
// checked. After the last byte the parser is back in reset for the next file.
// ----------------------------------------------------------------------------
module png_chunk_deframer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcd_pkg::pcd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pcd_pkg::pcd_out_t out_data
);
  import pcd_pkg::*;

  pcd_out_t result;
  logic     step;

  assign step = in_valid && in_ready;

  pcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_item (in_data),
    .result  (result)
  );

  pcd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
